/* rtl/cds_pkg.sv */
// Package with shared types and constants of the chroma downsampler.
package cds_pkg;

  localparam int unsigned PixelW = 24;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned PosW   = 6;
  localparam int unsigned BlockW = 2;
  localparam int unsigned LogW   = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 2;
  localparam int unsigned AccW   = 24;

  localparam logic [LogW-1:0] FactorLog2Reset   = 2'd1;
  localparam logic            VerticalModeReset = 1'b0;
  localparam logic [LogW-1:0] FactorLog2Max     = 2'd2;

  // Color conversion coefficients in 16-bit fixed point.
  localparam logic [AccW-1:0] CoefCbR   = 24'd11056;
  localparam logic [AccW-1:0] CoefCbG   = 24'd21712;
  localparam logic [AccW-1:0] CoefCrG   = 24'd27440;
  localparam logic [AccW-1:0] CoefCrB   = 24'd5328;
  localparam logic [AccW-1:0] ChromaOfs = 24'd8388608;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFactorLog2   = 1'b0,
    CfgVerticalMode = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } rgb_t;

  typedef struct packed {
    logic [LogW-1:0] factor_log2;
    logic            vertical_mode;
  } cfg_t;

endpackage

/* rtl/cds_if.sv */
// Handshake interfaces for the input, result and configuration channels.
interface cds_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_a;
  logic [23:0] pixel_b;
  logic [23:0] pixel_c;
  logic [23:0] pixel_d;
  logic [5:0]  source_position;
  logic [1:0]  source_block;

  modport source (output valid, pixel_a, pixel_b, pixel_c, pixel_d, source_position,
                  source_block, input ready);
  modport sink (input valid, pixel_a, pixel_b, pixel_c, pixel_d, source_position,
                source_block, output ready);
endinterface

interface cds_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  chroma_blue;
  logic [7:0]  chroma_red;
  logic [23:0] averaged_pixel;
  logic [5:0]  dest_position;

  modport source (output valid, chroma_blue, chroma_red, averaged_pixel, dest_position,
                  input ready);
  modport sink (input valid, chroma_blue, chroma_red, averaged_pixel, dest_position,
                output ready);
endinterface

interface cds_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/chroma_downsample_rgb_to_cbcr.sv */
// Top level of the chroma downsampler with input and result registers.
//
// The input channel carries up to four packed pixels plus the source position
// and source block. The first 1, 2 or 4 pixels, as set by the factor register,
// are averaged per channel; the result carries Cb, Cr, the averaged pixel and
// the position in the destination 8x8 chroma block.
// Every input transaction gives exactly one result transaction.
// An accepted transaction is held in the input register, converted
// combinationally and presented from the result register.
// One transaction is accepted every cycle as long as the
// receiver takes results; throughput is one item per cycle.
// When the receiver stalls, the result register holds its data and the input
// register fills; input ready drops only when both are occupied.
// The configuration channel is always ready; the user must write it only while idle (not enforced).
// Reset empties both registers and sets factor_log2 to 1 and horizontal mode.
module chroma_downsample_rgb_to_cbcr (
  input  logic clk_i,
  input  logic rst_ni,
  cds_in_if.sink    in_i,
  cds_cfg_if.sink   cfg_i,
  cds_out_if.source out_o
);
  import cds_pkg::*;

  cfg_t              cfg_q;
  logic              s1_valid_q, s1_valid_d;
  logic [PixelW-1:0] pa_q, pb_q, pc_q, pd_q;
  logic [PosW-1:0]   pos_q;
  logic [BlockW-1:0] blk_q;
  logic              out_valid_q, out_valid_d;
  logic [ChanW-1:0]  cb_q, cr_q, cb_d, cr_d;
  rgb_t              avg_q, avg_d;
  logic [PosW-1:0]   dest_q, dest_d;
  logic              s2_ready, s1_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.factor_log2   <= FactorLog2Reset;
      cfg_q.vertical_mode <= VerticalModeReset;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CfgFactorLog2:   cfg_q.factor_log2   <= cfg_i.data;
        CfgVerticalMode: cfg_q.vertical_mode <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign s2_ready    = !out_valid_q || out_o.ready;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign in_i.ready  = s1_ready;
  assign s1_valid_d  = s1_ready ? in_i.valid : s1_valid_q;
  assign out_valid_d = s2_ready ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && s1_ready) begin
      pa_q  <= in_i.pixel_a;
      pb_q  <= in_i.pixel_b;
      pc_q  <= in_i.pixel_c;
      pd_q  <= in_i.pixel_d;
      pos_q <= in_i.source_position;
      blk_q <= in_i.source_block;
    end
  end

  cds_merge u_merge (
    .pixel_a_i         (pa_q),
    .pixel_b_i         (pb_q),
    .pixel_c_i         (pc_q),
    .pixel_d_i         (pd_q),
    .source_position_i (pos_q),
    .source_block_i    (blk_q),
    .cfg_i             (cfg_q),
    .avg_o             (avg_d),
    .dest_position_o   (dest_d)
  );

  cds_color u_color (
    .avg_i         (avg_d),
    .chroma_blue_o (cb_d),
    .chroma_red_o  (cr_d)
  );

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      cb_q   <= cb_d;
      cr_q   <= cr_d;
      avg_q  <= avg_d;
      dest_q <= dest_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.chroma_blue    = cb_q;
  assign out_o.chroma_red     = cr_q;
  assign out_o.averaged_pixel = avg_q;
  assign out_o.dest_position  = dest_q;

endmodule

/* rtl/cds_merge.sv */
// Per-channel pixel averaging and destination position computation.
module cds_merge (
  input  logic [cds_pkg::PixelW-1:0] pixel_a_i,
  input  logic [cds_pkg::PixelW-1:0] pixel_b_i,
  input  logic [cds_pkg::PixelW-1:0] pixel_c_i,
  input  logic [cds_pkg::PixelW-1:0] pixel_d_i,
  input  logic [cds_pkg::PosW-1:0]   source_position_i,
  input  logic [cds_pkg::BlockW-1:0] source_block_i,
  input  cds_pkg::cfg_t              cfg_i,
  output cds_pkg::rgb_t              avg_o,
  output logic [cds_pkg::PosW-1:0]   dest_position_o
);
  import cds_pkg::*;

  logic [LogW-1:0]  lg;
  rgb_t             px_a, px_b, px_c, px_d;
  logic [ChanW+1:0] sum_b, sum_g, sum_r;
  logic [2:0]       row_idx, col_idx;
  logic [7:0]       row_full, blk_h, blk_v, dest_h, dest_v;

  assign lg   = (cfg_i.factor_log2 > FactorLog2Max) ? FactorLog2Max : cfg_i.factor_log2;
  assign px_a = pixel_a_i;
  assign px_b = pixel_b_i;
  assign px_c = pixel_c_i;
  assign px_d = pixel_d_i;

  always_comb begin
    sum_b = 10'(px_a.blue);
    sum_g = 10'(px_a.green);
    sum_r = 10'(px_a.red);
    if (lg != 2'd0) begin
      sum_b = sum_b + 10'(px_b.blue);
      sum_g = sum_g + 10'(px_b.green);
      sum_r = sum_r + 10'(px_b.red);
    end
    if (lg == FactorLog2Max) begin
      sum_b = sum_b + 10'(px_c.blue) + 10'(px_d.blue);
      sum_g = sum_g + 10'(px_c.green) + 10'(px_d.green);
      sum_r = sum_r + 10'(px_c.red) + 10'(px_d.red);
    end
  end

  assign avg_o.blue  = 8'(sum_b >> lg);
  assign avg_o.green = 8'(sum_g >> lg);
  assign avg_o.red   = 8'(sum_r >> lg);

  assign row_idx  = source_position_i[5:3];
  assign col_idx  = source_position_i[2:0];
  assign row_full = {2'b00, row_idx, 3'b000};
  assign blk_h    = {3'b000, source_block_i, 3'b000} >> lg;
  assign blk_v    = {source_block_i, 6'b000000} >> lg;
  assign dest_h   = row_full + (8'(col_idx) >> lg) + blk_h;
  assign dest_v   = (row_full >> lg) + 8'(col_idx) + blk_v;

  assign dest_position_o = cfg_i.vertical_mode ? dest_v[PosW-1:0] : dest_h[PosW-1:0];

endmodule

/* rtl/cds_color.sv */
// Fixed-point conversion of an averaged pixel to JPEG Cb and Cr.
module cds_color (
  input  cds_pkg::rgb_t             avg_i,
  output logic [cds_pkg::ChanW-1:0] chroma_blue_o,
  output logic [cds_pkg::ChanW-1:0] chroma_red_o
);
  import cds_pkg::*;

  logic [AccW-1:0] b_ext, g_ext, r_ext;
  logic [AccW-1:0] cb_acc, cr_acc;

  assign b_ext = AccW'(avg_i.blue);
  assign g_ext = AccW'(avg_i.green);
  assign r_ext = AccW'(avg_i.red);

  // The sums always stay within 0 to 2^24 - 1, so the upper byte is the result.
  assign cb_acc = ChromaOfs + (b_ext << 15) - r_ext * CoefCbR - g_ext * CoefCbG;
  assign cr_acc = ChromaOfs + (r_ext << 15) - g_ext * CoefCrG - b_ext * CoefCrB;

  assign chroma_blue_o = cb_acc[AccW-1:AccW-ChanW];
  assign chroma_red_o  = cr_acc[AccW-1:AccW-ChanW];

endmodule

/* sim/tb_chroma_downsample_rgb_to_cbcr.sv */
// Self-checking testbench of the chroma downsampler: predicts and checks every result.
module tb_chroma_downsample_rgb_to_cbcr;
  import cds_pkg::*;

  typedef struct packed {
    rgb_t              pixel_a;
    rgb_t              pixel_b;
    rgb_t              pixel_c;
    rgb_t              pixel_d;
    logic [PosW-1:0]   source_position;
    logic [BlockW-1:0] source_block;
  } pixel_group_t;

  typedef struct packed {
    logic [ChanW-1:0] chroma_blue;
    logic [ChanW-1:0] chroma_red;
    rgb_t             averaged_pixel;
    logic [PosW-1:0]  dest_position;
  } chroma_result_t;

  localparam longint HalfFx = 32768;
  localparam int unsigned HoldCycles = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cds_in_if  in_if ();
  cds_cfg_if cfg_if ();
  cds_out_if out_if ();

  chroma_downsample_rgb_to_cbcr uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  chroma_result_t pending_results[$];
  cfg_t           merge_cfg;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;
  int unsigned    hold_request = 0;
  int unsigned    hold_seen = 0;
  int unsigned    hold_left = 0;
  int unsigned    accepted_items = 0;
  int unsigned    checked_results = 0;
  int unsigned    register_writes = 0;
  int unsigned    error_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [ChanW-1:0] clamp_chroma(longint acc);
    longint shifted;
    if (acc < 0) begin
      return '0;
    end
    shifted = acc >>> 16;
    if (shifted > 255) begin
      return 8'hFF;
    end
    return shifted[ChanW-1:0];
  endfunction

  function automatic chroma_result_t predict_chroma(pixel_group_t g, cfg_t c);
    rgb_t           px[4];
    int unsigned    lg;
    int unsigned    sum_b;
    int unsigned    sum_g;
    int unsigned    sum_r;
    int unsigned    k;
    int unsigned    m;
    int unsigned    row;
    int unsigned    col;
    int unsigned    dest;
    longint         avg_b;
    longint         avg_g;
    longint         avg_r;
    longint         cb_fx;
    longint         cr_fx;
    chroma_result_t r;
    lg = (c.factor_log2 > FactorLog2Max) ? FactorLog2Max : c.factor_log2;
    px[0] = g.pixel_a;
    px[1] = g.pixel_b;
    px[2] = g.pixel_c;
    px[3] = g.pixel_d;
    sum_b = 0;
    sum_g = 0;
    sum_r = 0;
    for (int p = 0; p < (1 << lg); p++) begin
      sum_b += px[p].blue;
      sum_g += px[p].green;
      sum_r += px[p].red;
    end
    avg_b = sum_b >> lg;
    avg_g = sum_g >> lg;
    avg_r = sum_r >> lg;
    cb_fx = HalfFx * avg_b - longint'(CoefCbR) * avg_r - longint'(CoefCbG) * avg_g
            + longint'(ChromaOfs);
    cr_fx = HalfFx * avg_r - longint'(CoefCrG) * avg_g - longint'(CoefCrB) * avg_b
            + longint'(ChromaOfs);
    k = g.source_position;
    m = g.source_block;
    row = k & 56;
    col = k & 7;
    if (c.vertical_mode) begin
      dest = (row >> lg) + col + ((64 * m) >> lg);
    end else begin
      dest = row + (col >> lg) + ((8 * m) >> lg);
    end
    r.chroma_blue = clamp_chroma(cb_fx);
    r.chroma_red = clamp_chroma(cr_fx);
    r.averaged_pixel.blue = avg_b[ChanW-1:0];
    r.averaged_pixel.green = avg_g[ChanW-1:0];
    r.averaged_pixel.red = avg_r[ChanW-1:0];
    r.dest_position = dest[PosW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    error_count++;
    if (error_count <= 50) begin
      $display("mismatch in %s at result %0d: got 0x%0h, expected 0x%0h",
               what, checked_results, got, want);
    end
  endtask

  always @(posedge clk) begin
    chroma_result_t want;
    pixel_group_t   grp;
    if (!rst_n) begin
      merge_cfg.factor_log2 = FactorLog2Reset;
      merge_cfg.vertical_mode = VerticalModeReset;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        register_writes++;
        case (cfg_idx_e'(cfg_if.index))
          CfgFactorLog2: begin
            merge_cfg.factor_log2 = cfg_if.data;
          end
          CfgVerticalMode: begin
            merge_cfg.vertical_mode = cfg_if.data[0];
          end
          default: begin
          end
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        grp = {in_if.pixel_a, in_if.pixel_b, in_if.pixel_c, in_if.pixel_d,
               in_if.source_position, in_if.source_block};
        pending_results.push_back(predict_chroma(grp, merge_cfg));
        accepted_items++;
      end
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", out_if.dest_position, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_if.chroma_blue !== want.chroma_blue) begin
            report_mismatch("chroma_blue", out_if.chroma_blue, want.chroma_blue);
          end
          if (out_if.chroma_red !== want.chroma_red) begin
            report_mismatch("chroma_red", out_if.chroma_red, want.chroma_red);
          end
          if (out_if.averaged_pixel !== want.averaged_pixel) begin
            report_mismatch("averaged_pixel", out_if.averaged_pixel, want.averaged_pixel);
          end
          if (out_if.dest_position !== want.dest_position) begin
            report_mismatch("dest_position", out_if.dest_position, want.dest_position);
          end
        end
        checked_results++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_request != hold_seen) begin
      hold_seen <= hold_request;
      out_if.ready <= 1'b0;
      hold_left <= HoldCycles - 1;
    end else if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic pixel_group_t make_group(logic [PixelW-1:0] a, logic [PixelW-1:0] b,
                                              logic [PixelW-1:0] c, logic [PixelW-1:0] d,
                                              logic [PosW-1:0] pos, logic [BlockW-1:0] blk);
    pixel_group_t g;
    g.pixel_a = a;
    g.pixel_b = b;
    g.pixel_c = c;
    g.pixel_d = d;
    g.source_position = pos;
    g.source_block = blk;
    return g;
  endfunction

  function automatic logic [PixelW-1:0] random_pixel();
    logic [PixelW-1:0] px;
    px = PixelW'($urandom());
    if ($urandom_range(7) == 0) begin
      for (int ch = 0; ch < 3; ch++) begin
        px[ch*8 +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
      end
    end
    return px;
  endfunction

  function automatic pixel_group_t random_group();
    return make_group(random_pixel(), random_pixel(), random_pixel(), random_pixel(),
                      PosW'($urandom_range(63)), BlockW'($urandom_range(3)));
  endfunction

  task automatic send_pixel_group(pixel_group_t g);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.pixel_a <= g.pixel_a;
    in_if.pixel_b <= g.pixel_b;
    in_if.pixel_c <= g.pixel_c;
    in_if.pixel_d <= g.pixel_d;
    in_if.source_position <= g.source_position;
    in_if.source_block <= g.source_block;
    @(posedge clk);
    while (!in_if.ready) begin
      @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    @(posedge clk);
    while (!cfg_if.ready) begin
      @(posedge clk);
    end
  endtask

  task automatic apply_setting(logic [LogW-1:0] lg, logic vert);
    wait_for_drain();
    write_register(CfgFactorLog2, lg);
    write_register(CfgVerticalMode, {1'b0, vert});
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_setting();
    send_idle_pct = 23;
    recv_idle_pct = 51;
    send_pixel_group(make_group(24'hFFFFFF, 24'h000000, 24'h123456, 24'hABCDEF, 6'd63, 2'd3));
    send_pixel_group(make_group(24'h0000FF, 24'hFF0000, 24'h00FF00, 24'h000000, 6'd5, 2'd1));
  endtask

  task automatic test_directed_extremes();
    for (int lg = 0; lg < 4; lg++) begin
      for (int vert = 0; vert < 2; vert++) begin
        apply_setting(LogW'(lg), vert[0]);
        send_pixel_group(make_group(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                    6'd63, 2'd3));
        send_pixel_group(make_group(24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                    6'd0, 2'd0));
        send_pixel_group(make_group(24'hFF0000, 24'h0000FF, 24'h00FF00, 24'hFFFFFF,
                                    6'd7, 2'd1));
      end
    end
  endtask

  task automatic test_backpressure();
    apply_setting(2'd2, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request++;
    repeat (40) send_pixel_group(random_group());
    wait_for_drain();
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 51;
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int chunk = 0; chunk < 6; chunk++) begin
        apply_setting(LogW'(chunk % 4), 1'((chunk + phase) % 2));
        repeat (55) send_pixel_group(random_group());
      end
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.pixel_a = '0;
    in_if.pixel_b = '0;
    in_if.pixel_c = '0;
    in_if.pixel_d = '0;
    in_if.source_position = '0;
    in_if.source_block = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CfgFactorLog2;
    cfg_if.data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_setting();
    test_directed_extremes();
    test_backpressure();
    test_random_phases();

    wait_for_drain();
    repeat (10) @(posedge clk);
    $display("Covered reset defaults, all factor codes in both placement modes, pixel extremes,");
    $display("%0d transactions in, %0d results checked, %0d register writes, %0d mismatches.",
             accepted_items, checked_results, register_writes, error_count);
    if (error_count == 0) begin
      $display("[chroma_downsample_rgb_to_cbcr] OK");
    end else begin
      $display("[chroma_downsample_rgb_to_cbcr] ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Timed out with %0d results still pending.", pending_results.size());
    $display("[chroma_downsample_rgb_to_cbcr] ERROR");
    $finish;
  end

endmodule

/* files.f */
rtl/cds_pkg.sv
rtl/cds_if.sv
rtl/cds_merge.sv
rtl/cds_color.sv
rtl/chroma_downsample_rgb_to_cbcr.sv
sim/tb_chroma_downsample_rgb_to_cbcr.sv
